@@ rtl/qai_pkg.sv @@
// shared types, widths and constants of the quaternion attitude integrator
// no dependencies
`default_nettype none

package qai_pkg;

    localparam int DATA_W = 32;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 66;
    localparam int ACC_W  = 64;
    localparam int INC_W  = 49;
    localparam int ROOT_W = 32;
    localparam int MAG_W  = 31;

    localparam logic signed [INC_W-1:0] SAT_POS = 49'sd2147483647;
    localparam logic signed [INC_W-1:0] SAT_NEG = -49'sd2147483647;

    // quaternion component codes
    localparam logic [1:0] COMP_W = 2'd0;
    localparam logic [1:0] COMP_X = 2'd1;
    localparam logic [1:0] COMP_Y = 2'd2;
    localparam logic [1:0] COMP_Z = 2'd3;

    // step codes inside one component
    localparam logic [2:0] TERM_OX  = 3'd0;
    localparam logic [2:0] TERM_OY  = 3'd1;
    localparam logic [2:0] TERM_OZ  = 3'd2;
    localparam logic [2:0] TERM_LO  = 3'd3;
    localparam logic [2:0] TERM_HI  = 3'd4;

    typedef struct packed {
        logic [1:0] qsel;
        logic       neg;
    } term_sel_t;

    // hamilton product (0,omega)*q: which q component and sign goes with each omega term
    function automatic term_sel_t term_sel(input logic [1:0] comp, input logic [1:0] term);
        term_sel_t s;
        s.qsel = COMP_W;
        s.neg  = 1'b0;
        case ({comp, term})
            {COMP_W, 2'd0}: begin s.qsel = COMP_X; s.neg = 1'b1; end
            {COMP_W, 2'd1}: begin s.qsel = COMP_Y; s.neg = 1'b1; end
            {COMP_W, 2'd2}: begin s.qsel = COMP_Z; s.neg = 1'b1; end
            {COMP_X, 2'd0}: begin s.qsel = COMP_W; s.neg = 1'b0; end
            {COMP_X, 2'd1}: begin s.qsel = COMP_Z; s.neg = 1'b0; end
            {COMP_X, 2'd2}: begin s.qsel = COMP_Y; s.neg = 1'b1; end
            {COMP_Y, 2'd0}: begin s.qsel = COMP_Z; s.neg = 1'b1; end
            {COMP_Y, 2'd1}: begin s.qsel = COMP_W; s.neg = 1'b0; end
            {COMP_Y, 2'd2}: begin s.qsel = COMP_X; s.neg = 1'b0; end
            {COMP_Z, 2'd0}: begin s.qsel = COMP_Y; s.neg = 1'b0; end
            {COMP_Z, 2'd1}: begin s.qsel = COMP_X; s.neg = 1'b1; end
            {COMP_Z, 2'd2}: begin s.qsel = COMP_W; s.neg = 1'b0; end
            default: begin s.qsel = COMP_W; s.neg = 1'b0; end
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/quaternion_attitude_integrator_top.sv @@
// quaternion attitude integrator: euler step with saturation and renormalization
// depends on qai_pkg, qai_mul, qai_sqrt, qai_div
// load and zero-omega items go straight to the output step; integrate items run the
// product, square, square root and divide steps, most of the time going to the shared divider
// throughput: one item at a time, the next is taken once the result is in the output register
// synchronous active-low reset sets the quaternion to (1,0,0,0) and empties the output
`default_nettype none

module quaternion_attitude_integrator_top #(
    parameter int QUAT_FRAC_BITS = 30
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_cmd,
    input  wire logic signed [31:0] s_omega_x,
    input  wire logic signed [31:0] s_omega_y,
    input  wire logic signed [31:0] s_omega_z,
    input  wire logic [31:0]        s_step_time,
    input  wire logic signed [31:0] s_load_w,
    input  wire logic signed [31:0] s_load_x,
    input  wire logic signed [31:0] s_load_y,
    input  wire logic signed [31:0] s_load_z,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_att_w,
    output logic signed [31:0]      m_att_x,
    output logic signed [31:0]      m_att_y,
    output logic signed [31:0]      m_att_z,
    output logic                    m_skipped
);

    localparam int DW = qai_pkg::DATA_W;

    typedef enum logic [2:0] {
        S_IDLE, S_PROD, S_SQ, S_SQRT, S_DIV, S_DONE
    } state_t;

    state_t state_reg;
    logic   phase_reg;
    logic [1:0] comp_reg;
    logic [2:0] term_reg;

    logic signed [DW-1:0] quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg;
    logic signed [DW-1:0] n_w_reg, n_x_reg, n_y_reg, n_z_reg;
    logic signed [DW-1:0] om_x_reg, om_y_reg, om_z_reg;
    logic [DW-1:0]        dt_reg;
    logic signed [qai_pkg::ACC_W-1:0] acc_reg;
    logic [DW-1:0]        hi32_reg;
    logic                 skip_reg;
    logic                 m_valid_reg;
    logic signed [DW-1:0] att_w_reg, att_x_reg, att_y_reg, att_z_reg;
    logic                 skipped_reg;

    logic signed [qai_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [qai_pkg::PROD_W-1:0] p_reg;
    qai_pkg::term_sel_t   tsel;
    logic signed [DW-1:0] q_term, q_comp, n_comp, om_term;
    logic [qai_pkg::ACC_W-1:0] acc_mag;
    logic signed [qai_pkg::ACC_W-1:0] p_half;
    logic [qai_pkg::ACC_W-1:0] inc_sum;
    logic signed [qai_pkg::INC_W-1:0] inc_s, n_full;
    logic signed [DW-1:0] n_sat;
    logic [qai_pkg::MAG_W-1:0] n_mag;
    logic signed [DW-1:0] div_res;

    logic sqrt_start, sqrt_busy, sqrt_done;
    logic [qai_pkg::ROOT_W-1:0] root;
    logic div_start, div_done;
    logic [QUAT_FRAC_BITS:0] quot;

    function automatic logic signed [DW-1:0] pick4(input logic [1:0] sel,
        input logic signed [DW-1:0] a, input logic signed [DW-1:0] b,
        input logic signed [DW-1:0] c, input logic signed [DW-1:0] d);
        logic signed [DW-1:0] r;
        r = a;
        case (sel)
            qai_pkg::COMP_W: r = a;
            qai_pkg::COMP_X: r = b;
            qai_pkg::COMP_Y: r = c;
            default:         r = d;
        endcase
        return r;
    endfunction

    assign tsel    = qai_pkg::term_sel(comp_reg, term_reg[1:0]);
    assign q_term  = pick4(tsel.qsel, quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg);
    assign q_comp  = pick4(comp_reg, quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg);
    assign n_comp  = pick4(comp_reg, n_w_reg, n_x_reg, n_y_reg, n_z_reg);
    assign om_term = pick4(term_reg[1:0], om_x_reg, om_y_reg, om_z_reg, om_z_reg);
    assign acc_mag = acc_reg[qai_pkg::ACC_W-1] ? qai_pkg::ACC_W'(-acc_reg) : acc_reg;
    assign p_half  = p_reg[qai_pkg::ACC_W:1];

    // |d|*dt >> 48 from the two partial products
    assign inc_sum = {1'b0, p_reg[62:0]} + qai_pkg::ACC_W'(hi32_reg);
    assign inc_s   = acc_reg[qai_pkg::ACC_W-1] ? -$signed({1'b0, inc_sum[63:16]})
                                               : $signed({1'b0, inc_sum[63:16]});
    assign n_full  = qai_pkg::INC_W'(q_comp) + inc_s;
    assign n_sat   = (n_full > qai_pkg::SAT_POS) ? qai_pkg::SAT_POS[DW-1:0] :
                     (n_full < qai_pkg::SAT_NEG) ? qai_pkg::SAT_NEG[DW-1:0] : n_full[DW-1:0];

    assign n_mag   = n_comp[DW-1] ? qai_pkg::MAG_W'(-n_comp) : n_comp[qai_pkg::MAG_W-1:0];
    assign div_res = n_comp[DW-1] ? -$signed(DW'(quot)) : $signed(DW'(quot));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_PROD) begin
            case (term_reg)
                qai_pkg::TERM_LO: begin
                    mul_a = qai_pkg::MUL_W'(acc_mag[31:0]);
                    mul_b = qai_pkg::MUL_W'(dt_reg);
                end
                qai_pkg::TERM_HI: begin
                    mul_a = qai_pkg::MUL_W'(acc_mag[62:32]);
                    mul_b = qai_pkg::MUL_W'(dt_reg);
                end
                default: begin
                    mul_a = qai_pkg::MUL_W'(om_term);
                    mul_b = qai_pkg::MUL_W'(q_term);
                end
            endcase
        end else if (state_reg == S_SQ) begin
            mul_a = qai_pkg::MUL_W'(n_comp);
            mul_b = qai_pkg::MUL_W'(n_comp);
        end
    end

    assign sqrt_start = (state_reg == S_SQRT) && !phase_reg;
    assign div_start  = (state_reg == S_DIV) && !phase_reg;

    qai_mul u_mul (
        .aclk  (aclk),
        .a_in  (mul_a),
        .b_in  (mul_b),
        .p_reg (p_reg)
    );

    qai_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (acc_reg),
        .busy_reg (sqrt_busy),
        .done_reg (sqrt_done),
        .root     (root)
    );

    qai_div #(.FRAC_BITS(QUAT_FRAC_BITS)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (n_mag),
        .divisor  (root),
        .done_reg (div_done),
        .quot_reg (quot)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_att_w   = att_w_reg;
    assign m_att_x   = att_x_reg;
    assign m_att_y   = att_y_reg;
    assign m_att_z   = att_z_reg;
    assign m_skipped = skipped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= 1'b0;
            comp_reg    <= qai_pkg::COMP_W;
            term_reg    <= qai_pkg::TERM_OX;
            m_valid_reg <= 1'b0;
            skip_reg    <= 1'b0;
            quat_w_reg  <= DW'(64'd1 << QUAT_FRAC_BITS);
            quat_x_reg  <= '0;
            quat_y_reg  <= '0;
            quat_z_reg  <= '0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        om_x_reg  <= s_omega_x;
                        om_y_reg  <= s_omega_y;
                        om_z_reg  <= s_omega_z;
                        dt_reg    <= s_step_time;
                        comp_reg  <= qai_pkg::COMP_W;
                        term_reg  <= qai_pkg::TERM_OX;
                        phase_reg <= 1'b0;
                        skip_reg  <= 1'b0;
                        if (s_cmd) begin
                            quat_w_reg <= s_load_w;
                            quat_x_reg <= s_load_x;
                            quat_y_reg <= s_load_y;
                            quat_z_reg <= s_load_z;
                            state_reg  <= S_DONE;
                        end else if (s_omega_x == '0 && s_omega_y == '0 && s_omega_z == '0) begin
                            skip_reg  <= 1'b1;
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_PROD;
                        end
                    end
                end
                S_PROD: begin
                    phase_reg <= !phase_reg;
                    if (phase_reg) begin
                        case (term_reg)
                            qai_pkg::TERM_LO: hi32_reg <= p_reg[63:32];
                            qai_pkg::TERM_HI: begin
                                case (comp_reg)
                                    qai_pkg::COMP_W: n_w_reg <= n_sat;
                                    qai_pkg::COMP_X: n_x_reg <= n_sat;
                                    qai_pkg::COMP_Y: n_y_reg <= n_sat;
                                    default:         n_z_reg <= n_sat;
                                endcase
                            end
                            qai_pkg::TERM_OX: acc_reg <= tsel.neg ? -p_half : p_half;
                            default: acc_reg <= tsel.neg ? acc_reg - p_half : acc_reg + p_half;
                        endcase
                        if (term_reg == qai_pkg::TERM_HI) begin
                            term_reg <= qai_pkg::TERM_OX;
                            comp_reg <= comp_reg + 2'd1;
                            if (comp_reg == qai_pkg::COMP_Z) begin
                                acc_reg   <= '0;
                                state_reg <= S_SQ;
                            end
                        end else begin
                            term_reg <= term_reg + 3'd1;
                        end
                    end
                end
                S_SQ: begin
                    phase_reg <= !phase_reg;
                    if (phase_reg) begin
                        acc_reg  <= acc_reg + p_reg[qai_pkg::ACC_W-1:0];
                        comp_reg <= comp_reg + 2'd1;
                        if (comp_reg == qai_pkg::COMP_Z) begin
                            state_reg <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    phase_reg <= 1'b1;
                    if (phase_reg && sqrt_done) begin
                        phase_reg <= 1'b0;
                        comp_reg  <= qai_pkg::COMP_W;
                        if (root == '0) begin
                            // zero norm: keep the saturated sums as they are
                            quat_w_reg <= n_w_reg;
                            quat_x_reg <= n_x_reg;
                            quat_y_reg <= n_y_reg;
                            quat_z_reg <= n_z_reg;
                            state_reg  <= S_DONE;
                        end else begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    phase_reg <= 1'b1;
                    if (phase_reg && div_done) begin
                        phase_reg <= 1'b0;
                        case (comp_reg)
                            qai_pkg::COMP_W: quat_w_reg <= div_res;
                            qai_pkg::COMP_X: quat_x_reg <= div_res;
                            qai_pkg::COMP_Y: quat_y_reg <= div_res;
                            default:         quat_z_reg <= div_res;
                        endcase
                        comp_reg <= comp_reg + 2'd1;
                        if (comp_reg == qai_pkg::COMP_Z) begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        att_w_reg   <= quat_w_reg;
                        att_x_reg   <= quat_x_reg;
                        att_y_reg   <= quat_y_reg;
                        att_z_reg   <= quat_z_reg;
                        skipped_reg <= skip_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_sqrt_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_busy |-> state_reg == S_SQRT) else $error("square root running outside its step");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid
            && $stable({m_att_w, m_att_x, m_att_y, m_att_z, m_skipped}))
        else $error("result changed while stalled");

    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd |=> state_reg == S_DONE)
        else $error("load request did not go straight to output");

endmodule

`default_nettype wire

@@ rtl/qai_mul.sv @@
// shared registered 33x33 signed multiplier
// depends on qai_pkg
`default_nettype none

module qai_mul (
    input  wire logic                                  aclk,
    input  wire logic signed [qai_pkg::MUL_W-1:0]      a_in,
    input  wire logic signed [qai_pkg::MUL_W-1:0]      b_in,
    output logic signed [qai_pkg::PROD_W-1:0]          p_reg
);

    always_ff @(posedge aclk) begin
        p_reg <= a_in * b_in;
    end

endmodule

`default_nettype wire

@@ rtl/qai_sqrt.sv @@
// iterative 64-bit integer square root, one result bit per cycle
// depends on qai_pkg
`default_nettype none

module qai_sqrt (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [qai_pkg::ACC_W-1:0]         radicand,
    output logic                                   busy_reg,
    output logic                                   done_reg,
    output logic [qai_pkg::ROOT_W-1:0]             root
);

    logic [qai_pkg::ACC_W-1:0] rem_reg;
    logic [qai_pkg::ACC_W-1:0] res_reg;
    logic [qai_pkg::ACC_W-1:0] bit_reg;
    logic [5:0]                cnt_reg;
    logic [qai_pkg::ACC_W:0]   trial;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign root  = res_reg[qai_pkg::ROOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
                rem_reg  <= radicand;
                res_reg  <= '0;
                bit_reg  <= qai_pkg::ACC_W'(64'd1 << 62);
            end else if (busy_reg) begin
                if ({1'b0, rem_reg} >= trial) begin
                    rem_reg <= rem_reg - trial[qai_pkg::ACC_W-1:0];
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("sqrt done held longer than one cycle");

endmodule

`default_nettype wire

@@ rtl/qai_div.sv @@
// iterative restoring divider for normalization, one quotient bit per cycle
// depends on qai_pkg; needs dividend <= divisor so the quotient fits FRAC_BITS+1 bits
`default_nettype none

module qai_div #(
    parameter int FRAC_BITS = 30
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [qai_pkg::MAG_W-1:0]     dividend,
    input  wire logic [qai_pkg::ROOT_W-1:0]    divisor,
    output logic                               done_reg,
    output logic [FRAC_BITS:0]                 quot_reg
);

    localparam int REM_W = qai_pkg::ROOT_W + 2;
    localparam int CNT_W = $clog2(FRAC_BITS + 2);

    logic [REM_W-1:0]          rem_reg;
    logic [qai_pkg::ROOT_W-1:0] dvs_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic [REM_W-1:0]          dvs_ext;
    logic                      qbit;
    logic [REM_W-1:0]          rem_sub;

    assign dvs_ext = REM_W'(dvs_reg);
    assign qbit    = rem_reg >= dvs_ext;
    assign rem_sub = qbit ? rem_reg - dvs_ext : rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FRAC_BITS + 1);
                rem_reg  <= REM_W'(dividend);
                dvs_reg  <= divisor;
                quot_reg <= '0;
            end else if (busy_reg) begin
                rem_reg  <= {rem_sub[REM_W-2:0], 1'b0};
                quot_reg <= {quot_reg[FRAC_BITS-1:0], qbit};
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("divider done while still busy");

endmodule

`default_nettype wire
